/* rtl/core/lpfc_pkg.sv */
// ----------------------------------------------------------------------------
// lpfc_pkg: shared types and constants
// This package holds the request and result payloads, the sizes of the page
// store and the address map of the control register.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfc_pkg;

  localparam int unsigned MAX_FRAMES = 128;
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CAP_W      = 8;
  localparam int unsigned IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned RANK_W     = IDX_W;
  localparam int unsigned CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int unsigned ENT_W      = PAGE_W + RANK_W;
  localparam int unsigned CMP_W      = 16;
  localparam int unsigned QDEPTH     = 2;

  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0]   CAP_RESET     = 8'd128;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last_ref;
  } req_t;

  typedef struct packed {
    logic               fault;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_total;
    logic               sequence_done;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/lru_page_fault_counter.sv */
// ----------------------------------------------------------------------------
// lru_page_fault_counter: LRU page store with fault counter
// Fully associative store of up to 128 pages with least-recently-used
// replacement. The engine sweeps the frame memory twice, one frame a cycle:
// first to find the page, the victim and the free frame, then to age the
// recency ranks. It passes through the SCAN, SEND, DEC, UPD and DRAIN states
// for a request taken from the queue, then presents the result, and takes the
// next request only once that result is taken. A two-entry queue takes
// requests while the engine works or a result waits. The user must see that
// capacity is written through the APB port at address 0 while idle; the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_fault_counter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lpfc_pkg::req_t               req_i,
  input  wire logic                         req_valid_i,
  output logic                              req_stall_o,
  output lpfc_pkg::rsp_t                    rsp_o,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_stall_i,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lpfc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [lpfc_pkg::PDATA_W-1:0] pwdata,
  output logic [lpfc_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  logic [lpfc_pkg::CAP_W-1:0] capacity_q;
  lpfc_pkg::req_t             head;
  logic                       head_valid;
  logic                       pop;

  assign pready = 1'b1;
  assign prdata = (paddr == lpfc_pkg::ADDR_CAPACITY) ?
                  lpfc_pkg::PDATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lpfc_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr == lpfc_pkg::ADDR_CAPACITY) begin
      capacity_q <= pwdata[lpfc_pkg::CAP_W-1:0];
    end
  end

  lpfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .req_valid_i  (req_valid_i),
    .req_stall_o  (req_stall_o),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  lpfc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_i   (capacity_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .rsp_o        (rsp_o),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_stall_i  (rsp_stall_i)
  );

endmodule

`default_nettype wire

/* rtl/core/lpfc_queue.sv */
// ----------------------------------------------------------------------------
// lpfc_queue: request intake queue
// Two-entry queue that takes page requests from the input channel and hands
// them to the replacement engine, so either side may stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lpfc_pkg::req_t req_i,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  output lpfc_pkg::req_t     head_o,
  output logic               head_valid_o,
  input  wire logic          pop_i
);

  lpfc_pkg::req_t slot_q [lpfc_pkg::QDEPTH];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push;
  logic           pop;

  assign req_stall_o  = (fill_q == 2'(lpfc_pkg::QDEPTH));
  assign head_valid_o = (fill_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  assign push = req_valid_i && !req_stall_o;
  assign pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lpfc_engine.sv */
// ----------------------------------------------------------------------------
// lpfc_engine: LRU replacement engine
// Scans the frame store for the requested page, the victim and the first free
// frame, then sweeps it again to age the recency ranks and place the page.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfc_engine (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [lpfc_pkg::CAP_W-1:0] capacity_i,
  input  wire lpfc_pkg::req_t             head_i,
  input  wire logic                       head_valid_i,
  output logic                            pop_o,
  output lpfc_pkg::rsp_t                  rsp_o,
  output logic                            rsp_valid_o,
  input  wire logic                       rsp_stall_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SEND  = 3'd2;
  localparam logic [2:0] ST_DEC   = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  localparam logic [lpfc_pkg::IDX_W-1:0] IDX_LAST = lpfc_pkg::IDX_W'(lpfc_pkg::MAX_FRAMES - 1);

  logic [2:0]                      state_q;
  logic [lpfc_pkg::IDX_W-1:0]      addr_q;
  lpfc_pkg::req_t                  req_q;

  logic [lpfc_pkg::ENT_W-1:0]      mem_q [lpfc_pkg::MAX_FRAMES];
  logic [lpfc_pkg::ENT_W-1:0]      rd_data_q;
  logic [lpfc_pkg::IDX_W-1:0]      rd_idx_q;
  logic                            rd_vld_q;
  logic                            rd_upd_q;
  logic                            rd_en;

  logic [lpfc_pkg::MAX_FRAMES-1:0] valid_q;
  logic [lpfc_pkg::CNT_W-1:0]      cnt_q;
  logic [lpfc_pkg::COUNT_W-1:0]    faults_q;

  logic                            hit_q, victim_q, free_q;
  logic [lpfc_pkg::IDX_W-1:0]      hit_idx_q, victim_idx_q, free_idx_q, slot_q;
  logic [lpfc_pkg::RANK_W-1:0]     hit_rank_q;
  logic [lpfc_pkg::PAGE_W-1:0]     victim_page_q;

  lpfc_pkg::rsp_t                  rsp_q;
  logic                            rsp_valid_q;

  logic [lpfc_pkg::PAGE_W-1:0]     rd_page;
  logic [lpfc_pkg::RANK_W-1:0]     rd_rank;
  logic                            rd_live;
  logic [lpfc_pkg::CMP_W-1:0]      cap_eff;
  logic                            evict;
  logic [lpfc_pkg::IDX_W-1:0]      slot;
  logic [lpfc_pkg::COUNT_W-1:0]    faults_next;
  logic [lpfc_pkg::ENT_W-1:0]      wr_data;
  logic                            wr_en;
  logic                            aged;

  assign rd_page = rd_data_q[lpfc_pkg::ENT_W-1:lpfc_pkg::RANK_W];
  assign rd_rank = rd_data_q[lpfc_pkg::RANK_W-1:0];
  assign rd_live = valid_q[rd_idx_q];
  assign rd_en   = (state_q == ST_SCAN) || (state_q == ST_UPD);
  assign pop_o   = (state_q == ST_IDLE) && head_valid_i && !rsp_valid_q;

  always_comb begin
    cap_eff = lpfc_pkg::CMP_W'(capacity_i);
    if (cap_eff == '0) begin
      cap_eff = lpfc_pkg::CMP_W'(1);
    end else if (cap_eff > lpfc_pkg::CMP_W'(lpfc_pkg::MAX_FRAMES)) begin
      cap_eff = lpfc_pkg::CMP_W'(lpfc_pkg::MAX_FRAMES);
    end
    evict       = !hit_q && (lpfc_pkg::CMP_W'(cnt_q) >= cap_eff);
    slot        = hit_q ? hit_idx_q : (evict ? victim_idx_q : free_idx_q);
    faults_next = (hit_q || faults_q == lpfc_pkg::COUNT_MAX) ? faults_q
                                                              : faults_q + 1'b1;
    aged        = rd_live && (!hit_q || rd_rank < hit_rank_q);
    wr_en       = rd_vld_q && rd_upd_q;
    if (rd_idx_q == slot_q) begin
      wr_data = {req_q.page, lpfc_pkg::RANK_W'(0)};
    end else if (aged) begin
      wr_data = {rd_page, rd_rank + lpfc_pkg::RANK_W'(1)};
    end else begin
      wr_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[rd_idx_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_upd_q    <= 1'b0;
      rd_idx_q    <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      faults_q    <= '0;
      hit_q       <= 1'b0;
      victim_q    <= 1'b0;
      free_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      rd_upd_q <= (state_q == ST_UPD);
      rd_idx_q <= addr_q;
      if (rsp_valid_q && !rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (rd_vld_q && !rd_upd_q) begin
        if (rd_live && !hit_q && rd_page == req_q.page) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= rd_idx_q;
          hit_rank_q <= rd_rank;
        end
        if (rd_live && !victim_q &&
            lpfc_pkg::CNT_W'(rd_rank) == cnt_q - lpfc_pkg::CNT_W'(1)) begin
          victim_q      <= 1'b1;
          victim_idx_q  <= rd_idx_q;
          victim_page_q <= rd_page;
        end
        if (!rd_live && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= rd_idx_q;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            req_q    <= head_i;
            hit_q    <= 1'b0;
            victim_q <= 1'b0;
            free_q   <= 1'b0;
            addr_q   <= '0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == IDX_LAST) begin
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          state_q <= ST_DEC;
        end
        ST_DEC: begin
          slot_q         <= slot;
          valid_q[slot]  <= 1'b1;
          faults_q       <= faults_next;
          if (!hit_q && !evict) begin
            cnt_q <= cnt_q + 1'b1;
          end
          rsp_q.fault         <= !hit_q;
          rsp_q.evicted_valid <= evict;
          rsp_q.evicted_page  <= evict ? victim_page_q : '0;
          rsp_q.fault_total   <= faults_next;
          rsp_q.sequence_done <= req_q.last_ref;
          addr_q              <= '0;
          state_q             <= ST_UPD;
        end
        ST_UPD: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == IDX_LAST) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          rsp_valid_q <= 1'b1;
          if (req_q.last_ref) begin
            valid_q  <= '0;
            cnt_q    <= '0;
            faults_q <= '0;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lpfc_pkg::CNT_W'(lpfc_pkg::MAX_FRAMES))
    else $error("resident count above store depth");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(valid_q) == 32'(cnt_q)))
    else $error("resident count disagrees with valid frames");

  a_evict_is_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.evicted_valid) |-> rsp_q.fault)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_q.evicted_valid) |-> (rsp_q.evicted_page == '0))
    else $error("evicted page not zero without eviction");

endmodule

`default_nettype wire
